@@ hdl/jrdz_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package jrdz_pkg;

  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned FRAC_BITS   = SAMPLE_BITS - 1;
  localparam int unsigned DZ_BITS     = 15;
  localparam logic [DZ_BITS-1:0] DZ_RESET = 15'd9830;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] x_in;
    logic signed [SAMPLE_BITS-1:0] y_in;
  } sample_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] x_out;
    logic signed [SAMPLE_BITS-1:0] y_out;
  } result_t;

  typedef enum logic [1:0] {
    TC_ZERO,
    TC_FULL,
    TC_DIV
  } tcls_e;

endpackage
`default_nettype wire

@@ hdl/jrdz_pdiv.sv @@
`timescale 1ns / 1ps
`default_nettype none
module jrdz_pdiv #(
  parameter int unsigned DW = 31,
  parameter int unsigned VW = 16,
  parameter int unsigned SW = 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          v_i,
  input  wire logic [DW-1:0] dvd_i,
  input  wire logic [VW-1:0] dvs_i,
  input  wire logic [SW-1:0] sb_i,
  output logic               v_o,
  output logic      [DW-1:0] quo_o,
  output logic      [SW-1:0] sb_o
);

  logic          v_q   [DW+1];
  logic [VW-1:0] rem_q [DW+1];
  logic [DW-1:0] dvd_q [DW+1];
  logic [DW-1:0] quo_q [DW+1];
  logic [VW-1:0] dvs_q [DW+1];
  logic [SW-1:0] sb_q  [DW+1];

  always_comb begin
    v_q[0]   = v_i;
    rem_q[0] = '0;
    dvd_q[0] = dvd_i;
    quo_q[0] = '0;
    dvs_q[0] = dvs_i;
    sb_q[0]  = sb_i;
  end

  for (genvar k = 0; k < DW; k++) begin : g_stage
    logic [VW:0]   tr;
    logic [VW:0]   diff;
    logic          ge;
    logic [VW-1:0] rem_d;

    always_comb begin
      tr    = {rem_q[k], dvd_q[k][DW-1-k]};
      diff  = tr - {1'b0, dvs_q[k]};
      ge    = tr >= {1'b0, dvs_q[k]};
      rem_d = ge ? diff[VW-1:0] : tr[VW-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k+1] <= rem_d;
      dvd_q[k+1] <= dvd_q[k];
      quo_q[k+1] <= {quo_q[k][DW-2:0], ge};
      dvs_q[k+1] <= dvs_q[k];
      sb_q[k+1]  <= sb_q[k];
    end
  end

  assign v_o   = v_q[DW];
  assign quo_o = quo_q[DW];
  assign sb_o  = sb_q[DW];

endmodule
`default_nettype wire

@@ hdl/joystick_radial_dead_zone_top.sv @@
// Throughput: one request per cycle; busy_o is never raised, as the receiver cannot stall.
// The latency is set by the square root stages, the ratio divider and then the parallel x and y dividers.
// Reset clears all valid bits and loads the dead zone register with its default.
`timescale 1ns / 1ps
`default_nettype none
module joystick_radial_dead_zone_top (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire jrdz_pkg::sample_t     sample_i,
  output logic                       busy_o,
  output logic                       valid_o,
  output jrdz_pkg::result_t          result_o,
  input  wire logic                  dz_we_i,
  input  wire logic [jrdz_pkg::DZ_BITS-1:0] dz_wdata_i
);
  import jrdz_pkg::*;

  localparam int unsigned N   = SAMPLE_BITS;
  localparam int unsigned F   = FRAC_BITS;
  localparam int unsigned QSB = 2 * N + 3;
  localparam int unsigned TSB = 3 * N + 5;
  localparam int unsigned ODW = 2 * F + 1;
  localparam logic [N-1:0] ONE = N'(1) << F;
  localparam logic [ODW-1:0] LIM_POS = ODW'((N'(1) << F) - N'(1));
  localparam logic [ODW-1:0] LIM_NEG = ODW'(N'(1) << F);

  logic [DZ_BITS-1:0] dz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dz_q <= DZ_RESET;
    end else if (dz_we_i) begin
      dz_q <= dz_wdata_i;
    end
  end

  assign busy_o = 1'b0;

  logic         v1_q, v2_q, v3_q;
  logic [N-1:0] ax1_q, ay1_q, ax2_q, ay2_q;
  logic         sx1_q, sy1_q, sx2_q, sy2_q;
  logic [2*N-1:0] sqx2_q, sqy2_q, s3_q;
  logic [QSB-1:0] sb3_q;
  logic [N-1:0] ax_d, ay_d;

  always_comb begin
    ax_d = sample_i.x_in[N-1] ? N'(-sample_i.x_in) : N'(sample_i.x_in);
    ay_d = sample_i.y_in[N-1] ? N'(-sample_i.y_in) : N'(sample_i.y_in);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= start_i & ~busy_o;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ax1_q  <= ax_d;
    ay1_q  <= ay_d;
    sx1_q  <= sample_i.x_in[N-1];
    sy1_q  <= sample_i.y_in[N-1];
    sqx2_q <= ax1_q * ax1_q;
    sqy2_q <= ay1_q * ay1_q;
    ax2_q  <= ax1_q;
    ay2_q  <= ay1_q;
    sx2_q  <= sx1_q;
    sy2_q  <= sy1_q;
    s3_q   <= sqx2_q + sqy2_q;
    sb3_q  <= {ax2_q, ay2_q, sx2_q, sy2_q, 1'b0};
  end

  // Square root, one result bit per stage.
  logic           qv_q   [N+1];
  logic [2*N-1:0] qs_q   [N+1];
  logic [N:0]     qrem_q [N+1];
  logic [N-1:0]   qrt_q  [N+1];
  logic [QSB-1:0] qsb_q  [N+1];

  always_comb begin
    qv_q[0]   = v3_q;
    qs_q[0]   = s3_q;
    qrem_q[0] = '0;
    qrt_q[0]  = '0;
    qsb_q[0]  = {sb3_q[QSB-1:1], s3_q == '0};
  end

  for (genvar i = 0; i < N; i++) begin : g_sqrt
    logic [N+2:0] tr;
    logic [N+2:0] trial;
    logic [N+2:0] diff;
    logic         ge;

    always_comb begin
      tr    = {qrem_q[i], qs_q[i][2*N-1 -: 2]};
      trial = {1'b0, qrt_q[i], 2'b01};
      diff  = tr - trial;
      ge    = tr >= trial;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        qv_q[i+1] <= 1'b0;
      end else begin
        qv_q[i+1] <= qv_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      qs_q[i+1]   <= {qs_q[i][2*N-3:0], 2'b00};
      qrem_q[i+1] <= ge ? diff[N:0] : tr[N:0];
      qrt_q[i+1]  <= {qrt_q[i][N-2:0], ge};
      qsb_q[i+1]  <= qsb_q[i];
    end
  end

  logic [F-1:0] d;

  if (F >= DZ_BITS) begin : g_dz_up
    assign d = F'(dz_q) << (F - DZ_BITS);
  end else begin : g_dz_dn
    assign d = F'(dz_q >> (DZ_BITS - F));
  end

  logic [N-1:0] m_c, num_c, den_c;
  tcls_e        cls_c;

  always_comb begin
    m_c   = qrt_q[N];
    num_c = m_c - N'(d);
    den_c = ONE - N'(d);
    if (m_c <= N'(d)) begin
      cls_c = TC_ZERO;
    end else if (num_c >= den_c) begin
      cls_c = TC_FULL;
    end else begin
      cls_c = TC_DIV;
    end
  end

  logic         v4_q;
  logic [N-1:0] num4_q, den4_q;
  logic [TSB-1:0] sb4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= qv_q[N];
    end
  end

  always_ff @(posedge clk_i) begin
    num4_q <= num_c;
    den4_q <= den_c;
    sb4_q  <= {qsb_q[N], m_c, cls_c};
  end

  logic           tv;
  logic [2*F-1:0] tquo;
  logic [TSB-1:0] tsb;

  jrdz_pdiv #(
    .DW(2 * F),
    .VW(N),
    .SW(TSB)
  ) u_tdiv (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .v_i   (v4_q),
    .dvd_i ({num4_q[F-1:0], F'(0)}),
    .dvs_i (den4_q),
    .sb_i  (sb4_q),
    .v_o   (tv),
    .quo_o (tquo),
    .sb_o  (tsb)
  );

  logic [N-1:0] ax_t, ay_t, m_t;
  logic         sx_t, sy_t, z_t;
  tcls_e        cls_t;

  always_comb begin
    {ax_t, ay_t, sx_t, sy_t, z_t, m_t} = tsb[TSB-1:2];
    cls_t = tcls_e'(tsb[1:0]);
  end

  logic         v5_q, v6_q, v7_q;
  logic [N-1:0] t5_q, ax5_q, ay5_q, m5_q, m6_q;
  logic [2:0]   f5_q, f6_q, f7_q;
  logic [2*N-1:0] px6_q, py6_q;
  logic [ODW-1:0] dx7_q, dy7_q, m7_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else begin
      v5_q <= tv;
      v6_q <= v5_q;
      v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cls_t)
      TC_ZERO: t5_q <= '0;
      TC_FULL: t5_q <= ONE;
      TC_DIV:  t5_q <= tquo[N-1:0];
      default: t5_q <= '0;
    endcase
    ax5_q <= ax_t;
    ay5_q <= ay_t;
    m5_q  <= m_t;
    f5_q  <= {sx_t, sy_t, z_t};
    px6_q <= ax5_q * t5_q;
    py6_q <= ay5_q * t5_q;
    m6_q  <= m5_q;
    f6_q  <= f5_q;
    dx7_q <= ODW'(px6_q) + ODW'(m6_q >> 1);
    dy7_q <= ODW'(py6_q) + ODW'(m6_q >> 1);
    m7_q  <= ODW'(m6_q);
    f7_q  <= f6_q;
  end

  logic           xv, yv;
  logic [ODW-1:0] qx, qy;
  logic [2:0]     fo;
  logic           yfo;

  jrdz_pdiv #(
    .DW(ODW),
    .VW(N),
    .SW(3)
  ) u_xdiv (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .v_i   (v7_q),
    .dvd_i (dx7_q),
    .dvs_i (m7_q[N-1:0]),
    .sb_i  (f7_q),
    .v_o   (xv),
    .quo_o (qx),
    .sb_o  (fo)
  );

  jrdz_pdiv #(
    .DW(ODW),
    .VW(N),
    .SW(1)
  ) u_ydiv (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .v_i   (v7_q),
    .dvd_i (dy7_q),
    .dvs_i (m7_q[N-1:0]),
    .sb_i  (f7_q[0]),
    .v_o   (yv),
    .quo_o (qy),
    .sb_o  (yfo)
  );

  function automatic logic [N-1:0] sat_axis(input logic [ODW-1:0] q, input logic neg);
    logic [ODW-1:0] lim;
    lim = neg ? ((q > LIM_NEG) ? LIM_NEG : q) : ((q > LIM_POS) ? LIM_POS : q);
    return neg ? N'(ODW'(0) - lim) : lim[N-1:0];
  endfunction

  result_t res_d;

  always_comb begin
    if (yfo) begin
      res_d = '0;
    end else begin
      res_d.x_out = sat_axis(qx, fo[2]);
      res_d.y_out = sat_axis(qy, fo[1]);
    end
  end

  logic    vo_q;
  result_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else begin
      vo_q <= xv & yv;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o  = vo_q;
  assign result_o = res_q;

endmodule
`default_nettype wire
